>>> hdl/frame_interval_averager_assert.svh
// ----------------------------------------------------------------------------
// Frame interval averager assertion macros
// Shared clocked assertion forms used by the averager RTL.
// ----------------------------------------------------------------------------
`ifndef FRAME_INTERVAL_AVERAGER_ASSERT_SVH
`define FRAME_INTERVAL_AVERAGER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define FAI_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A cause that must be followed by an effect in the next cycle.
`define FAI_ASSERT_NEXT(lbl, clk, rst_n, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

>>> hdl/fai_pkg.sv
// ----------------------------------------------------------------------------
// Frame interval averager package
// Widths, reset constants and the divider status type shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package fai_pkg;

	// Width of intervals, averages and rates in timer ticks.
	localparam int unsigned DATA_W = 32;

	// Default number of intervals in the averaging window.
	localparam int unsigned WINDOW_DEPTH_DEF = 64;

	// Width of the one-second accumulator; it stays below twice a 32-bit limit.
	localparam int unsigned ACC_W = 34;

	// Reset value of the ticks-per-second register.
	localparam logic [DATA_W-1:0] TPS_RESET = 32'd1000000;

	// Status reported by the serial divider to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

>>> hdl/fai_ring.sv
// ----------------------------------------------------------------------------
// Interval ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fai_ring #(
	parameter int unsigned DEPTH  = fai_pkg::WINDOW_DEPTH_DEF,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [ADDR_W-1:0]         wr_addr,
	input  wire logic [fai_pkg::DATA_W-1:0] wr_data,
	input  wire logic                      rd_en,
	input  wire logic [ADDR_W-1:0]         rd_addr,
	output logic      [fai_pkg::DATA_W-1:0] rd_data
);

	logic [fai_pkg::DATA_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/fai_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, for the window mean.
// ----------------------------------------------------------------------------
`default_nettype none

module fai_div #(
	parameter int unsigned SUM_W = 38,
	parameter int unsigned CNT_W = 7
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [SUM_W-1:0]           dividend,
	input  wire logic [CNT_W-1:0]           divisor,
	output logic      [fai_pkg::DATA_W-1:0] quotient,
	output fai_pkg::div_status_t            status
);

	localparam int unsigned STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	// Shift the next dividend bit into the partial remainder and try the divisor.
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the quotient bits replace the dividend bits from the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, dsr_q}) : trial[CNT_W-1:0];
		end
	end

	// A mean never exceeds the largest interval, so the low bits hold it all.
	assign quotient    = quo_q[fai_pkg::DATA_W-1:0];
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

`default_nettype wire

>>> hdl/frame_interval_averager.sv
// The bit-serial divider produces one quotient bit of the window mean per cycle
// while busy, over SUM_W = 32 + clog2(WINDOW_DEPTH) dividend bits.
// The input is not ready while an interval is in work; a finished result may wait downstream.
// Reset (arst_n low) clears the window count, sum, average, rate counters and sets
// ticks_per_second to one million; the ring contents are left as they are.
// ----------------------------------------------------------------------------
// Frame interval averager
// Moving average of frame intervals with outlier rejection and a frame-rate
// counter over one-second windows, driven by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_interval_averager #(
	parameter int unsigned WINDOW_DEPTH = fai_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: ticks_per_second.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	// Input: [31:0] interval_ticks.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,
	// Output: [31:0] average_interval, [63:32] frame_rate.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,
	// Output: [0] sample_kept.
	output logic             m_axis_tuser
);

	`include "frame_interval_averager_assert.svh"

	localparam int unsigned DW    = fai_pkg::DATA_W;
	localparam int unsigned AW    = fai_pkg::ACC_W;
	localparam int unsigned PTR_W = $clog2(WINDOW_DEPTH);
	localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned SUM_W = DW + PTR_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_EVICT,
		ST_INSERT,
		ST_START,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                state_q;
	logic [DW-1:0]         tps_q;
	logic [DW-1:0]         interval_q;
	logic                  kept_q;
	logic [PTR_W-1:0]      wpos_q;
	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      sum_q;
	logic [DW-1:0]         avg_q;
	logic [DW-1:0]         frames_q;
	logic [AW-1:0]         acc_q;
	logic [DW-1:0]         rate_q;
	logic                  m_valid_q;
	logic [63:0]           m_data_q;
	logic                  m_user_q;

	logic                  in_req;
	logic                  out_req;
	logic                  cfg_req;
	logic                  full;
	logic [DW-1:0]         diff;
	logic                  ring_rd_en;
	logic                  ring_wr_en;
	logic [DW-1:0]         ring_rd_data;
	logic                  div_start;
	logic [DW-1:0]         div_quo;
	fai_pkg::div_status_t  div_stat;

	assign cfg_ready     = 1'b1;
	assign cfg_req       = cfg_valid && cfg_ready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_req        = s_axis_tvalid && s_axis_tready;
	assign out_req       = m_valid_q && m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	assign full       = (count_q == CNT_W'(WINDOW_DEPTH));
	assign diff       = (interval_q >= avg_q) ? (interval_q - avg_q) : (avg_q - interval_q);
	assign ring_rd_en = in_req;
	assign ring_wr_en = (state_q == ST_INSERT) && kept_q;
	assign div_start  = (state_q == ST_START) && (count_q != '0);

	// Ring of kept intervals; the oldest entry is read as the item is taken.
	fai_ring #(
		.DEPTH  (WINDOW_DEPTH),
		.ADDR_W (PTR_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (ring_wr_en),
		.wr_addr (wpos_q),
		.wr_data (interval_q),
		.rd_en   (ring_rd_en),
		.rd_addr (wpos_q),
		.rd_data (ring_rd_data)
	);

	// Divider for the floor mean of the window.
	fai_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.quotient (div_quo),
		.status   (div_stat)
	);

	// Input interval capture.
	always_ff @(posedge clk) begin
		if (in_req) begin
			interval_q <= s_axis_tdata;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= fai_pkg::TPS_RESET;
		end else if (cfg_req) begin
			tps_q <= cfg_data;
		end
	end

	// Sequencer with window, rate and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kept_q    <= 1'b0;
			wpos_q    <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			avg_q     <= '0;
			frames_q  <= '0;
			acc_q     <= '0;
			rate_q    <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= 1'b0;
		end else begin
			// Release the output once taken, unless a new result loads in the same cycle.
			if (out_req && (state_q != ST_OUT)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_req) begin
						state_q <= ST_TEST;
					end
				end
				// Outlier test against the old average; count the frame and accumulate the average.
				ST_TEST: begin
					kept_q <= (diff < tps_q);
					if (frames_q != '1) begin
						frames_q <= frames_q + 1'b1;
					end
					acc_q   <= acc_q + AW'(avg_q);
					state_q <= ST_EVICT;
				end
				// Drop the oldest interval when a kept one meets a full window; close the second if due.
				ST_EVICT: begin
					if (kept_q && full) begin
						sum_q <= sum_q - SUM_W'(ring_rd_data);
					end
					if (acc_q > AW'(tps_q)) begin
						rate_q   <= frames_q;
						frames_q <= '0;
						acc_q    <= '0;
					end
					state_q <= ST_INSERT;
				end
				// Add the kept interval and advance the write position.
				ST_INSERT: begin
					if (kept_q) begin
						sum_q <= sum_q + SUM_W'(interval_q);
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
						if (wpos_q == PTR_W'(WINDOW_DEPTH - 1)) begin
							wpos_q <= '0;
						end else begin
							wpos_q <= wpos_q + 1'b1;
						end
					end
					state_q <= ST_START;
				end
				// An empty window averages to zero without dividing.
				ST_START: begin
					if (count_q == '0) begin
						avg_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						avg_q   <= div_quo;
						state_q <= ST_OUT;
					end
				end
				// Hand the result over once the output register is free.
				ST_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {rate_q, avg_q};
						m_user_q  <= kept_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The window count never passes its depth.
	`FAI_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(WINDOW_DEPTH), "window count beyond depth")
	// The write position stays inside the ring.
	`FAI_ASSERT_ALWAYS(a_wpos_bound, clk, arst_n, wpos_q <= PTR_W'(WINDOW_DEPTH - 1), "write position outside ring")
	// The divider is only started on a non-empty window while idle.
	`FAI_ASSERT_ALWAYS(a_div_start, clk, arst_n, !div_start || ((count_q != '0) && !div_stat.busy), "divider started badly")
	// The accumulator stays below twice a full 32-bit second.
	`FAI_ASSERT_ALWAYS(a_acc_bound, clk, arst_n, !acc_q[AW-1], "second accumulator overflow")
	// After a divider start the sequencer waits in ST_DIV with the divider busy.
	`FAI_ASSERT_NEXT(a_div_wait, clk, arst_n, div_start, (state_q == ST_DIV) && div_stat.busy, "divider not awaited")

endmodule

`default_nettype wire

>>> bench/frame_interval_averager_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame interval averager testbench
// Drives frame intervals through the input stream and checks every result
// against a cycle-free predictor of the window mean, the outlier rejection
// and the per-second frame counter. It covers directed edge cases of the
// limit register, then randomised runs of steady frame rates with jitter and
// outliers, random noise, and pauses that let the pipeline drain.
// ----------------------------------------------------------------------------

module frame_interval_averager_tb;

	localparam int unsigned WINDOW = fai_pkg::WINDOW_DEPTH_DEF;
	localparam int unsigned SETTLE_CYCLES = 60;
	localparam logic [31:0] LIMIT_MAX = '1;

	// One expected result: the window mean, the latched rate and the keep flag.
	typedef struct packed {
		logic [31:0] average;
		logic [31:0] rate;
		logic        kept;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] interval_ticks
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;   // [31:0] average_interval, [63:32] frame_rate
	logic        m_axis_tuser;   // [0] sample_kept

	// Predictor state, mirroring the block.
	logic [31:0] win_ring [WINDOW];
	int unsigned win_pos = 0;
	int unsigned win_count = 0;
	logic [63:0] win_sum = '0;
	logic [31:0] avg_now = '0;
	logic [31:0] frames_seen = '0;
	logic [63:0] sec_acc = '0;
	logic [31:0] rate_now = '0;
	logic [31:0] limit_now = fai_pkg::TPS_RESET;

	frame_result_t expected_frames [$];
	int unsigned   error_count = 0;
	int unsigned   stall_left = 0;
	bit            src_gaps = 1'b1;
	bit            sink_stalls = 1'b1;

	frame_interval_averager #(
		.WINDOW_DEPTH(WINDOW)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Random idle length: mostly short, now and then long.
	function automatic int unsigned rand_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(13, 60);
	endfunction

	// Works out the result of one frame and advances the predicted state.
	function automatic frame_result_t predict_frame(input logic [31:0] interval);
		logic [31:0]   diff;
		frame_result_t r;
		diff = (interval >= avg_now) ? interval - avg_now : avg_now - interval;
		r.kept = (diff < limit_now);
		if (r.kept) begin
			if (win_count >= WINDOW)
				win_sum = win_sum - win_ring[win_pos];
			else
				win_count++;
			win_ring[win_pos] = interval;
			win_sum = win_sum + interval;
			win_pos = (win_pos == WINDOW - 1) ? 0 : win_pos + 1;
		end
		// The rate counter works with the average in force before this frame.
		if (frames_seen != '1)
			frames_seen++;
		sec_acc = sec_acc + avg_now;
		if (sec_acc > {32'd0, limit_now}) begin
			rate_now = frames_seen;
			frames_seen = '0;
			sec_acc = '0;
		end
		avg_now = (win_count != 0) ? 32'(win_sum / win_count) : '0;
		r.average = avg_now;
		r.rate = rate_now;
		return r;
	endfunction

	// Receiver side: random back-pressure when enabled.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
			stall_left <= rand_gap() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compares every accepted result with the oldest expectation.
	always @(posedge clk) begin : check_result
		frame_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_frames.size() == 0) begin
				if (error_count < 10)
					$display("unexpected result: avg=%0d rate=%0d kept=%0d",
						m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
				error_count++;
			end else begin
				want = expected_frames.pop_front();
				if (m_axis_tdata[31:0] !== want.average
						|| m_axis_tdata[63:32] !== want.rate
						|| m_axis_tuser !== want.kept) begin
					if (error_count < 10)
						$display("mismatch: expected avg=%0d rate=%0d kept=%0d, got avg=%0d rate=%0d kept=%0d",
							want.average, want.rate, want.kept,
							m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
					error_count++;
				end
			end
		end
	end

	// Lowers the input request and holds it off for a number of cycles.
	task automatic idle_source(input int unsigned cycles);
		if (cycles != 0) begin
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Offers one interval and records its expected result once accepted.
	task automatic send_interval(input logic [31:0] value);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		do @(posedge clk); while (!s_axis_tready);
		expected_frames.push_back(predict_frame(value));
		if (src_gaps && $urandom_range(0, 2) == 0)
			idle_source(rand_gap());
	endtask

	// Stops sending and waits for every outstanding result.
	task automatic wait_drained();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
	endtask

	// Writes the ticks-per-second register once the block is idle.
	task automatic write_limit(input logic [31:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		limit_now = value;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Intervals around the reset limit, including both sides of the outlier edge.
	task automatic test_reset_limit();
		send_interval(32'd0);
		send_interval(32'd999_999);
		send_interval(avg_now + fai_pkg::TPS_RESET);
		send_interval(avg_now + fai_pkg::TPS_RESET - 1);
		send_interval(LIMIT_MAX);
	endtask

	// A narrow limit: one tick inside and exactly on the edge, above and below.
	task automatic test_limit_edges();
		write_limit(32'd100);
		send_interval(avg_now + 32'd99);
		send_interval(avg_now - 32'd99);
		send_interval(avg_now + 32'd100);
		send_interval(avg_now - 32'd100);
	endtask

	// A zero limit rejects every interval, even one equal to the average.
	task automatic test_zero_limit();
		write_limit(32'd0);
		send_interval(avg_now);
		send_interval(32'd0);
		send_interval(LIMIT_MAX);
	endtask

	// The widest limit keeps all but the farthest intervals.
	task automatic test_full_limit();
		write_limit(LIMIT_MAX);
		send_interval(LIMIT_MAX);
		send_interval(32'd0);
		send_interval(32'h7FFF_FFFF);
		send_interval(LIMIT_MAX);
		send_interval(32'h8000_0000);
	endtask

	// A steady frame rate with jitter, outliers and dropped frames.
	task automatic run_rate_phase(input logic [31:0] limit, input int unsigned count);
		int unsigned fps;
		int unsigned pick;
		logic [31:0] nominal;
		logic [31:0] jitter;
		logic [31:0] spread;
		fps = $urandom_range(2, 120);
		nominal = limit / fps;
		if (nominal == 0)
			nominal = 1;
		jitter = nominal >> 3;
		// Refill the window at the new rate if the old average would reject it.
		spread = (avg_now >= nominal) ? avg_now - nominal : nominal - avg_now;
		if (spread >= limit) begin
			write_limit(LIMIT_MAX);
			repeat (WINDOW) send_interval(nominal);
		end
		write_limit(limit);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 85)
				send_interval(nominal - jitter + $urandom_range(0, 2 * jitter));
			else if (pick < 93)
				send_interval($urandom());
			else if (pick < 97)
				send_interval(32'd0);
			else
				send_interval(avg_now + limit - $urandom_range(0, 1));
		end
	endtask

	// Several limits, the reset value and the maximum among them.
	task automatic test_rate_windows();
		run_rate_phase(fai_pkg::TPS_RESET, 350);
		run_rate_phase($urandom_range(20_000, 5_000_000), 350);
		// One stretch runs without idling on either side.
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		run_rate_phase($urandom_range(2_000, 100_000), 350);
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		run_rate_phase(LIMIT_MAX, 350);
	endtask

	// A limit of one tick keeps only intervals equal to the average.
	task automatic test_unit_limit();
		int unsigned pick;
		write_limit(32'd1);
		repeat (60) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				send_interval(avg_now);
			else if (pick < 7)
				send_interval(avg_now + 1);
			else if (pick < 8)
				send_interval(avg_now - 1);
			else
				send_interval($urandom());
		end
	endtask

	// Unstructured values under a random limit, single bits among them.
	task automatic test_noise();
		int unsigned pick;
		write_limit($urandom());
		repeat (300) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				send_interval($urandom());
			else if (pick < 9)
				send_interval(32'd1 << $urandom_range(0, 31));
			else
				send_interval(~(32'd1 << $urandom_range(0, 31)));
		end
	endtask

	// Bursts near the average, each followed by a full drain of the pipeline.
	task automatic test_drain_pause();
		repeat (4) begin
			repeat (30)
				send_interval(avg_now + $urandom_range(0, 1000) - 32'd500);
			wait_drained();
			idle_source(rand_gap());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_reset_limit();
		test_limit_edges();
		test_zero_limit();
		test_full_limit();
		test_rate_windows();
		test_unit_limit();
		test_noise();
		test_drain_pause();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_frames.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#60_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
